// ===== design/via_pkg.sv =====
// ----------------------------------------------------------------------------
// via_pkg: shared types and constants
// Opcodes, register numbers and the packed state of the interface adapter.
// ----------------------------------------------------------------------------
`default_nettype none

package via_pkg;

    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_PHASE1 = 2'd2,
        OP_PHASE2 = 2'd3
    } op_t;

    localparam logic [3:0] REG_ORB   = 4'h0;
    localparam logic [3:0] REG_ORA   = 4'h1;
    localparam logic [3:0] REG_DDRB  = 4'h2;
    localparam logic [3:0] REG_DDRA  = 4'h3;
    localparam logic [3:0] REG_T1CL  = 4'h4;
    localparam logic [3:0] REG_T1CH  = 4'h5;
    localparam logic [3:0] REG_T1LL  = 4'h6;
    localparam logic [3:0] REG_T1LH  = 4'h7;
    localparam logic [3:0] REG_T2CL  = 4'h8;
    localparam logic [3:0] REG_T2CH  = 4'h9;
    localparam logic [3:0] REG_SR    = 4'hA;
    localparam logic [3:0] REG_ACR   = 4'hB;
    localparam logic [3:0] REG_PCR   = 4'hC;
    localparam logic [3:0] REG_IFR   = 4'hD;
    localparam logic [3:0] REG_IER   = 4'hE;
    localparam logic [3:0] REG_ORA_NH = 4'hF;

    localparam logic [2:0] SR_IN_T2   = 3'd1;
    localparam logic [2:0] SR_IN_SYS  = 3'd2;
    localparam logic [2:0] SR_OUT_FREE = 3'd4;
    localparam logic [2:0] SR_OUT_T2  = 3'd5;
    localparam logic [2:0] SR_OUT_SYS = 3'd6;

    typedef struct packed {
        logic [7:0]  ora;
        logic [7:0]  orb;
        logic [7:0]  ddra;
        logic [7:0]  ddrb;
        logic [15:0] t1_count;
        logic [7:0]  t1_latch_lo;
        logic [7:0]  t1_latch_hi;
        logic        t1_running;
        logic        t1_armed;
        logic        t1_pb7;
        logic [15:0] t2_count;
        logic [7:0]  t2_latch_lo;
        logic        t2_running;
        logic        t2_armed;
        logic [7:0]  sr_data;
        logic [3:0]  sr_bits;
        logic [7:0]  sr_div;
        logic        sr_phase;
        logic [7:0]  acr;
        logic [7:0]  pcr;
        logic [7:0]  ifr;
        logic [6:0]  ier;
        logic        ca2;
        logic        cb2_hand;
        logic        cb2_shift;
    } via_state_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] reg_sel;
        logic [7:0] wdata;
        logic       cmp;
        logic [7:0] snd;
    } via_item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       strobe_a;
        logic       strobe_b;
    } via_side_t;

    localparam via_state_t ADAPTER_POWER_ON = '{
        ora: 8'h00, orb: 8'h00, ddra: 8'h00, ddrb: 8'h00,
        t1_count: 16'h0000, t1_latch_lo: 8'h00, t1_latch_hi: 8'h00,
        t1_running: 1'b0, t1_armed: 1'b0, t1_pb7: 1'b1,
        t2_count: 16'h0000, t2_latch_lo: 8'h00, t2_running: 1'b0, t2_armed: 1'b0,
        sr_data: 8'h00, sr_bits: 4'd8, sr_div: 8'h00, sr_phase: 1'b0,
        acr: 8'h00, pcr: 8'h00, ifr: 8'h00, ier: 7'h00,
        ca2: 1'b1, cb2_hand: 1'b1, cb2_shift: 1'b0
    };

endpackage

`default_nettype wire

// ===== design/versatile_interface_adapter_unit.sv =====
// ----------------------------------------------------------------------------
// versatile_interface_adapter_unit: 6522-style interface adapter
// Bus reads and writes, clock phases, two timers, shift register, handshakes.
// ----------------------------------------------------------------------------
// Each input transfer is one operation: bus read, bus write, clock phase one
// or clock phase two. The operation lands in an input register, the
// next-state logic updates the register file when the staged item advances
// and the result goes to an output register. The block takes one transfer
// per cycle while the result side keeps taking. Exactly one result transfer
// follows each input transfer, carrying the read data (zero unless a read),
// the interrupt line, port levels, port strobes and handshake line levels
// after the operation.
// Data-direction registers are stored but do not mask the port outputs.
`default_nettype none

module versatile_interface_adapter_unit
    import via_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [7:0] write_value, [8] compare_level, [16:9] sound_port_value, rest zero
    input  wire logic [23:0] s_tdata,
    // [1:0] opcode, [5:2] register_select
    input  wire logic [5:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [7:0] read_value, [15:8] port_a_level, [23:16] port_b_level,
    // [31:24] dac_x_value
    output logic [31:0]      m_tdata,
    // [0] irq_line, [1] port_a_strobe, [2] port_b_strobe, [3] ca2_level,
    // [4] cb2_hand_level, [5] cb2_shift_bit, [6] pb7_timer_level
    output logic [6:0]       m_tuser
);

    via_item_t  item_reg;
    logic       item_valid_reg;
    via_state_t state_reg;
    via_state_t state_next;
    via_side_t  side;
    logic [31:0] data_reg;
    logic [6:0]  user_reg;
    logic        out_valid_reg;
    logic        advance;

    via_core u_core (
        .cur  (state_reg),
        .item (item_reg),
        .nxt  (state_next),
        .side (side)
    );

    // Advance the staged item when the output register is free or draining.
    assign advance  = item_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            state_reg      <= ADAPTER_POWER_ON;
        end else begin
            if (s_tready) begin
                item_valid_reg <= s_tvalid;
            end
            if (advance) begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers: hold until the next transfer.
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= '{opcode: s_tuser[1:0], reg_sel: s_tuser[5:2],
                          wdata: s_tdata[7:0], cmp: s_tdata[8], snd: s_tdata[16:9]};
        end
        if (advance) begin
            data_reg <= {state_next.ora ^ 8'h80, state_next.orb, state_next.ora, side.rdata};
            user_reg <= {state_next.t1_pb7, state_next.cb2_shift, state_next.cb2_hand,
                         state_next.ca2, side.strobe_b, side.strobe_a, state_next.ifr[7]};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;

endmodule

`default_nettype wire

// ===== design/via_core.sv =====
// ----------------------------------------------------------------------------
// via_core: next-state logic
// Apply one operation to the register state and form the read data.
// ----------------------------------------------------------------------------
`default_nettype none

module via_core
    import via_pkg::*;
(
    input  via_state_t cur,
    input  via_item_t  item,
    output via_state_t nxt,
    output via_side_t  side
);

    logic [7:0]  pa_in;
    logic [15:0] t1_dec;
    logic [15:0] t2_dec;
    logic [7:0]  div_dec;
    logic        tick;
    logic [3:0]  bits_inc;

    always_comb begin
        nxt      = cur;
        side     = '0;
        tick     = 1'b0;
        pa_in    = (cur.orb[4:3] == 2'b01) ? item.snd : cur.ora;
        t1_dec   = cur.t1_count - 16'd1;
        t2_dec   = cur.t2_count - 16'd1;
        div_dec  = cur.sr_div - 8'd1;
        bits_inc = cur.sr_bits + 4'd1;

        case (op_t'(item.opcode))
            OP_READ: begin
                unique case (item.reg_sel)
                    REG_ORB: begin
                        if (cur.acr[7]) begin
                            side.rdata = (cur.orb & 8'h5F) | {cur.t1_pb7, 1'b0, item.cmp, 5'd0};
                        end else begin
                            side.rdata = (cur.orb & 8'hDF) | {2'b00, item.cmp, 5'd0};
                        end
                    end
                    REG_ORA: begin
                        if (cur.pcr[3:1] == 3'b100) nxt.ca2 = 1'b0;
                        side.rdata = pa_in;
                    end
                    REG_ORA_NH: side.rdata = pa_in;
                    REG_DDRB:   side.rdata = cur.ddrb;
                    REG_DDRA:   side.rdata = cur.ddra;
                    REG_T1CL: begin
                        nxt.ifr[6]     = 1'b0;
                        nxt.t1_running = 1'b0;
                        nxt.t1_armed   = 1'b0;
                        nxt.t1_pb7     = 1'b1;
                        side.rdata     = cur.t1_count[7:0];
                    end
                    REG_T1CH: side.rdata = cur.t1_count[15:8];
                    REG_T1LL: side.rdata = cur.t1_latch_lo;
                    REG_T1LH: side.rdata = cur.t1_latch_hi;
                    REG_T2CL: begin
                        nxt.ifr[5]     = 1'b0;
                        nxt.t2_running = 1'b0;
                        nxt.t2_armed   = 1'b0;
                        side.rdata     = cur.t2_count[7:0];
                    end
                    REG_T2CH: side.rdata = cur.t2_count[15:8];
                    REG_SR: begin
                        nxt.ifr[2]   = 1'b0;
                        nxt.sr_bits  = 4'd0;
                        nxt.sr_phase = 1'b1;
                        side.rdata   = cur.sr_data;
                    end
                    REG_ACR: side.rdata = cur.acr;
                    REG_PCR: side.rdata = cur.pcr;
                    REG_IFR: side.rdata = cur.ifr;
                    default: side.rdata = {1'b1, cur.ier};
                endcase
            end
            OP_WRITE: begin
                unique case (item.reg_sel)
                    REG_ORB: begin
                        nxt.orb       = item.wdata;
                        side.strobe_b = 1'b1;
                        if (cur.pcr[7:5] == 3'b100) nxt.cb2_hand = 1'b0;
                    end
                    REG_ORA: begin
                        if (cur.pcr[3:1] == 3'b100) nxt.ca2 = 1'b0;
                        nxt.ora       = item.wdata;
                        side.strobe_a = 1'b1;
                    end
                    REG_ORA_NH: begin
                        nxt.ora       = item.wdata;
                        side.strobe_a = 1'b1;
                    end
                    REG_DDRB: nxt.ddrb = item.wdata;
                    REG_DDRA: nxt.ddra = item.wdata;
                    REG_T1CL, REG_T1LL: nxt.t1_latch_lo = item.wdata;
                    REG_T1CH: begin
                        nxt.t1_latch_hi = item.wdata;
                        nxt.t1_count    = {item.wdata, cur.t1_latch_lo};
                        nxt.ifr[6]      = 1'b0;
                        nxt.t1_running  = 1'b1;
                        nxt.t1_armed    = 1'b1;
                        nxt.t1_pb7      = 1'b0;
                    end
                    REG_T1LH: nxt.t1_latch_hi = item.wdata;
                    REG_T2CL: nxt.t2_latch_lo = item.wdata;
                    REG_T2CH: begin
                        nxt.t2_count   = {item.wdata, cur.t2_latch_lo};
                        nxt.ifr[5]     = 1'b0;
                        nxt.t2_running = 1'b1;
                        nxt.t2_armed   = 1'b1;
                    end
                    REG_SR: begin
                        nxt.sr_data  = item.wdata;
                        nxt.ifr[2]   = 1'b0;
                        nxt.sr_bits  = 4'd0;
                        nxt.sr_phase = 1'b1;
                    end
                    REG_ACR: nxt.acr = item.wdata;
                    REG_PCR: begin
                        nxt.pcr      = item.wdata;
                        nxt.ca2      = (item.wdata[3:1] != 3'b110);
                        nxt.cb2_hand = (item.wdata[7:5] != 3'b110);
                    end
                    REG_IFR: nxt.ifr[6:0] = cur.ifr[6:0] & ~item.wdata[6:0];
                    default: begin
                        if (item.wdata[7]) nxt.ier = cur.ier | item.wdata[6:0];
                        else nxt.ier = cur.ier & ~item.wdata[6:0];
                    end
                endcase
            end
            OP_PHASE1: begin
                if (cur.t1_running) begin
                    nxt.t1_count = t1_dec;
                    if (t1_dec == 16'hFFFF) begin
                        if (cur.acr[6]) begin
                            nxt.ifr[6]   = 1'b1;
                            nxt.t1_pb7   = ~cur.t1_pb7;
                            nxt.t1_count = {cur.t1_latch_hi, cur.t1_latch_lo};
                        end else if (cur.t1_armed) begin
                            nxt.ifr[6]   = 1'b1;
                            nxt.t1_pb7   = 1'b1;
                            nxt.t1_armed = 1'b0;
                        end
                    end
                end
                if (cur.t2_running && !cur.acr[5]) begin
                    nxt.t2_count = t2_dec;
                    if (t2_dec == 16'hFFFF && cur.t2_armed) begin
                        nxt.ifr[5]   = 1'b1;
                        nxt.t2_armed = 1'b0;
                    end
                end
                nxt.sr_div = div_dec;
                if (div_dec == 8'hFF) begin
                    nxt.sr_div   = cur.t2_latch_lo;
                    tick         = cur.sr_phase;
                    nxt.sr_phase = ~cur.sr_phase;
                end
                if (!cur.sr_bits[3]) begin
                    case (cur.acr[4:2])
                        SR_IN_T2: if (tick) begin
                            nxt.sr_data = {cur.sr_data[6:0], 1'b0};
                            nxt.sr_bits = bits_inc;
                        end
                        SR_IN_SYS: begin
                            nxt.sr_data = {cur.sr_data[6:0], 1'b0};
                            nxt.sr_bits = bits_inc;
                        end
                        SR_OUT_FREE: if (tick) begin
                            nxt.cb2_shift = cur.sr_data[7];
                            nxt.sr_data   = {cur.sr_data[6:0], cur.sr_data[7]};
                        end
                        SR_OUT_T2: if (tick) begin
                            nxt.cb2_shift = cur.sr_data[7];
                            nxt.sr_data   = {cur.sr_data[6:0], cur.sr_data[7]};
                            nxt.sr_bits   = bits_inc;
                        end
                        SR_OUT_SYS: begin
                            nxt.cb2_shift = cur.sr_data[7];
                            nxt.sr_data   = {cur.sr_data[6:0], cur.sr_data[7]};
                            nxt.sr_bits   = bits_inc;
                        end
                        default: ;
                    endcase
                    if (nxt.sr_bits == 4'd8) nxt.ifr[2] = 1'b1;
                end
            end
            default: begin
                if (cur.pcr[3:1] == 3'b101) nxt.ca2 = 1'b1;
                if (cur.pcr[7:5] == 3'b101) nxt.cb2_hand = 1'b1;
            end
        endcase

        nxt.ifr[7] = |(nxt.ifr[6:0] & nxt.ier);
    end

endmodule

`default_nettype wire
